// ===== design/ssa_pkg.sv =====
// ----------------------------------------------------------------------------
// ssa_pkg
// Shared types and constants for the smoothstep amplitude unit.
// ----------------------------------------------------------------------------
package ssa_pkg;

  localparam int Points   = 16;
  localparam int IdxW     = $clog2(Points);
  localparam int FracBits = 16;
  localparam int DataW    = 32;
  localparam int CntW     = 5;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic [1:0] REG_INSIDE = 2'd0;
  localparam logic [1:0] REG_BEFORE = 2'd1;
  localparam logic [1:0] REG_AFTER  = 2'd2;
  localparam logic [1:0] REG_NONE   = 2'd3;

  // one classified item passed from front to back
  typedef struct packed {
    logic                    op;
    logic [IdxW-1:0]         idx;
    logic signed [DataW-1:0] ptime;
    logic signed [DataW-1:0] pamp;
    logic signed [DataW-1:0] etime;
  } item_t;

endpackage

// ===== design/ssa_front.sv =====
// ----------------------------------------------------------------------------
// ssa_front
// Input stage and two-entry queue between the input channel and the back end.
// ----------------------------------------------------------------------------
module ssa_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ssa_pkg::item_t      in_item,
  output logic                q_valid,
  input  logic                q_ready,
  output ssa_pkg::item_t      q_item
);

  ssa_pkg::item_t mem_r [2];
  logic           wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_item;
    end
  end

endmodule

// ===== design/ssa_back.sv =====
// ----------------------------------------------------------------------------
// ssa_back
// Table, segment search, serial divider, multiply sequence and result register.
// ----------------------------------------------------------------------------
module ssa_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [ssa_pkg::CntW-1:0]        num_points,
  input  logic                            q_valid,
  output logic                            q_ready,
  input  ssa_pkg::item_t                  q_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [ssa_pkg::DataW-1:0] out_amplitude,
  output logic [1:0]                      out_region
);

  localparam int DW = ssa_pkg::DataW;
  localparam int F  = ssa_pkg::FracBits;
  localparam int NW = DW + F;   // quotient bits produced before clamp

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SRCH = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic signed [DW-1:0] tim_r [ssa_pkg::Points];
  logic signed [DW-1:0] amp_r [ssa_pkg::Points];

  logic [2:0]            st_r, st_nxt;
  logic [ssa_pkg::CntW-1:0] cnt_r;
  logic [ssa_pkg::CntW-1:0] n_r;
  logic signed [DW-1:0]  t_r;
  logic signed [DW-1:0]  y1_r, y2_r;
  logic [DW-1:0]         den_r;
  logic [NW-1:0]         quo_r;
  logic [DW:0]           rem_r;
  logic [$clog2(NW+1)-1:0] dcnt_r;
  logic [2:0]            mstep_r;
  logic [F-1:0]          k_r, k2_r, k3_r;
  logic [F+4:0]          p_r;
  logic [F:0]            s_r;
  logic signed [DW:0]    dy_r;
  logic signed [DW+F+1:0] prod_r;
  logic signed [DW-1:0]  calc_amp_r;
  logic [1:0]            calc_reg_r;
  logic signed [DW-1:0]  res_amp_r;
  logic [1:0]            res_reg_r;
  logic                  ov_r;

  logic [ssa_pkg::IdxW-1:0] ia, ib;
  logic signed [DW-1:0]  xa, xb;
  logic                  hit;
  logic [DW+1:0]         rtry;
  logic                  qbit;
  logic [ssa_pkg::CntW-1:0] lastc;

  assign q_ready   = (st_r == ST_IDLE);
  assign out_valid = ov_r;
  assign out_amplitude = res_amp_r;
  assign out_region    = res_reg_r;

  assign ia   = n_r[ssa_pkg::IdxW-1:0] - 1'b1;
  assign ib   = n_r[ssa_pkg::IdxW-1:0];
  assign xa   = tim_r[ia];
  assign xb   = tim_r[ib];
  assign hit  = (t_r >= xa) && (t_r < xb);
  assign lastc = cnt_r - 1'b1;
  // restoring division step
  assign rtry = {1'b0, rem_r[DW-1:0], quo_r[NW-1]} - {2'b00, den_r};
  assign qbit = ~rtry[DW+1];

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (q_valid && q_item.op == ssa_pkg::OP_EVAL) st_nxt = ST_SRCH;
      ST_SRCH: if (cnt_r < ssa_pkg::CntW'(2)) st_nxt = ST_OUT;
               else if (hit) st_nxt = ST_DIV;
               else if (n_r == lastc[ssa_pkg::CntW-1:0]) st_nxt = ST_OUT;
      ST_DIV:  if (dcnt_r == NW[$clog2(NW+1)-1:0] - 1'b1) st_nxt = ST_MUL;
      ST_MUL:  if (mstep_r == 3'd5) st_nxt = ST_OUT;
      ST_OUT:  if (!ov_r || out_ready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (ov_r && out_ready) ov_r <= 1'b0;
      if (st_r == ST_OUT && (!ov_r || out_ready)) ov_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && q_valid) begin
      if (q_item.op == ssa_pkg::OP_LOAD) begin
        tim_r[q_item.idx] <= q_item.ptime;
        amp_r[q_item.idx] <= q_item.pamp;
      end
      t_r   <= q_item.etime;
      n_r   <= ssa_pkg::CntW'(1);
      cnt_r <= (num_points > ssa_pkg::CntW'(ssa_pkg::Points)) ?
               ssa_pkg::CntW'(ssa_pkg::Points) : num_points;
    end
    case (st_r)
      ST_SRCH: begin
        if (cnt_r < ssa_pkg::CntW'(2)) begin
          calc_amp_r <= '0;
          calc_reg_r <= ssa_pkg::REG_NONE;
        end else if (hit) begin
          y1_r   <= amp_r[ia];
          y2_r   <= amp_r[ib];
          den_r  <= DW'(xb - xa);
          quo_r  <= {DW'(t_r - xa), {F{1'b0}}};
          rem_r  <= '0;
          dcnt_r <= '0;
        end else if (n_r == lastc) begin
          if (t_r < tim_r[0]) begin
            calc_amp_r <= amp_r[0];
            calc_reg_r <= ssa_pkg::REG_BEFORE;
          end else if (t_r >= tim_r[lastc[ssa_pkg::IdxW-1:0]]) begin
            calc_amp_r <= amp_r[lastc[ssa_pkg::IdxW-1:0]];
            calc_reg_r <= ssa_pkg::REG_AFTER;
          end else begin
            calc_amp_r <= '0;
            calc_reg_r <= ssa_pkg::REG_NONE;
          end
        end else begin
          n_r <= n_r + 1'b1;
        end
      end
      ST_DIV: begin
        rem_r  <= qbit ? rtry[DW:0] : {rem_r[DW-1:0], quo_r[NW-1]};
        quo_r  <= {quo_r[NW-2:0], qbit};
        dcnt_r <= dcnt_r + 1'b1;
        mstep_r <= 3'd0;
      end
      ST_MUL: begin
        mstep_r <= mstep_r + 1'b1;
        case (mstep_r)
          3'd0: begin
            // clamp k below one
            k_r  <= (quo_r[NW-1:F] != '0) ? {F{1'b1}} : quo_r[F-1:0];
            dy_r <= (DW+1)'(y2_r) - (DW+1)'(y1_r);
          end
          3'd1: k2_r <= F'(({{F{1'b0}}, k_r} * {{F{1'b0}}, k_r}) >> F);
          3'd2: begin
            k3_r <= F'(({{F{1'b0}}, k2_r} * {{F{1'b0}}, k_r}) >> F);
            p_r  <= (F+5)'((10 << F)) - (F+5)'(15 * k_r) + (F+5)'(6 * k2_r);
          end
          3'd3: s_r <= (F+1)'(({{(F+5){1'b0}}, k3_r} * {{F{1'b0}}, p_r}) >> F);
          3'd4: prod_r <= dy_r * $signed({1'b0, s_r});
          3'd5: begin
            calc_amp_r <= DW'(y1_r + DW'(prod_r >>> F));
            calc_reg_r <= ssa_pkg::REG_INSIDE;
          end
          default: ;
        endcase
      end
      ST_OUT: begin
        // result moves to the output register once the previous one is taken
        if (!ov_r || out_ready) begin
          res_amp_r <= calc_amp_r;
          res_reg_r <= calc_reg_r;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== design/smooth_step_amplitude_unit.sv =====
// ----------------------------------------------------------------------------
// smooth_step_amplitude_unit
// Quintic smoothstep interpolation over a 16-entry breakpoint table.
// ----------------------------------------------------------------------------
//  port group | dir | handshake
//  in_*       | in  | in_valid / in_ready
//  out_*      | out | out_valid / out_ready
//  cfg_*      | in  | cfg_we, no wait
// a load item is written to the table when the back end accepts it; an evaluate
// item is accepted, then goes through segment search (one segment compare per cycle)
// and, inside a segment, a serial divide (one quotient bit per cycle) and
// 6 multiply steps, then the output state, held while the previous result waits
// reset clears control only; the table is undefined until written
// a two-entry queue lets the input side keep taking items while the back stalls
module smooth_step_amplitude_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [ssa_pkg::CntW-1:0]           cfg_num_points,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_operation,
  input  logic [3:0]                         in_point_index,
  input  logic signed [ssa_pkg::DataW-1:0]   in_point_time,
  input  logic signed [ssa_pkg::DataW-1:0]   in_point_amp,
  input  logic signed [ssa_pkg::DataW-1:0]   in_eval_time,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [ssa_pkg::DataW-1:0]   out_amplitude,
  output logic [1:0]                         out_region
);

  logic [ssa_pkg::CntW-1:0] num_points_r;
  ssa_pkg::item_t           in_item, q_item;
  logic                     q_valid, q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_points_r <= '0;
    end else if (cfg_we) begin
      num_points_r <= cfg_num_points;
    end
  end

  always_comb begin
    in_item.op    = in_operation;
    in_item.idx   = in_point_index;
    in_item.ptime = in_point_time;
    in_item.pamp  = in_point_amp;
    in_item.etime = in_eval_time;
  end

  ssa_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_item,
    .q_valid, .q_ready, .q_item
  );

  ssa_back u_back (
    .clk, .rst_n, .num_points(num_points_r), .q_valid, .q_ready, .q_item,
    .out_valid, .out_ready, .out_amplitude, .out_region
  );

  // a stalled result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_amplitude) && $stable(out_region))
    else $error("result changed under stall");

  // results without a usable segment carry a zero amplitude
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_region == ssa_pkg::REG_NONE |-> out_amplitude == '0)
    else $error("region check");

  // a full queue always has an item toward the back end
  a_q_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> q_valid)
    else $error("queue full but empty toward back end");

endmodule
